// ----- rtl/core/dtq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the delta timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int NUM_ENTRIES_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int DELTA_W         = 24;
    localparam int ID_W            = 16;
    localparam int ARG_W           = 32;
    localparam int ACTION_W        = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EXPIRE = 2'd2;

    // one stored timeout
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [ID_W-1:0]    cb_id;
        logic [ARG_W-1:0]   cb_arg;
    } entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TK_RD,
        ST_TK_EV,
        ST_IN_RD,
        ST_IN_EV,
        ST_SH_RD,
        ST_SH_WR,
        ST_IN_PUT,
        ST_FX_RD,
        ST_FX_WR,
        ST_EX_RD,
        ST_EX_EV,
        ST_EX_OUT,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/delta_timer_queue_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_timer_queue_top
// Ordered queue of pending timeouts kept as delays relative to the
// predecessor, stored in a circular single-port-read memory and walked by a
// small sequencer with one compare/subtract unit.
// ----------------------------------------------------------------------------
// Steps: a tick walks past zero-delta entries and ages the first nonzero one;
//   an insert compares entries, shifts later ones toward the tail, writes the
//   new entry and fixes up its successor (refused when full); an expire pops
//   due head entries (none when frozen or empty). Each report waits on output.
// A new item is accepted only in the idle state, once the last one is done.
// Reset: queue empty, head at zero, callouts not frozen; memory is not cleared.
// ----------------------------------------------------------------------------
module delta_timer_queue_top #(
    parameter int NUM_ENTRIES = dtq_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dtq_pkg::ACTION_W-1:0] action,
    input  wire logic [dtq_pkg::DELTA_W-1:0]  delay_ticks,
    input  wire logic [dtq_pkg::ID_W-1:0]     callback_id,
    input  wire logic [dtq_pkg::ARG_W-1:0]    callback_arg,
    // output channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              result_valid,
    output logic [dtq_pkg::ID_W-1:0]          expired_id,
    output logic [dtq_pkg::ARG_W-1:0]         expired_arg,
    output logic                              queue_full,
    output logic                              last_result
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int N_W   = $clog2(dtq_pkg::MAX_RESULTS + 1);

    // sequencer and queue state
    dtq_pkg::state_t               state_reg, state_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]              j_reg, j_next;
    logic [N_W-1:0]                n_reg, n_next;
    logic                          pend_reg, pend_next;
    logic                          frozen_reg;
    logic [dtq_pkg::DELTA_W-1:0]   t_reg, t_next;
    logic [dtq_pkg::ID_W-1:0]      id_reg, id_next;
    logic [dtq_pkg::ARG_W-1:0]     arg_reg, arg_next;
    logic                          rv_reg, rv_next;
    logic                          full_reg, full_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic                          o_valid_reg, o_valid_next;
    logic [dtq_pkg::ID_W-1:0]      o_id_reg, o_id_next;
    logic [dtq_pkg::ARG_W-1:0]     o_arg_reg, o_arg_next;
    logic                          o_full_reg, o_full_next;
    logic                          o_last_reg, o_last_next;

    // memory
    dtq_pkg::entry_t               mem [NUM_ENTRIES];
    dtq_pkg::entry_t               rd_data_reg;
    dtq_pkg::entry_t               mem_wd;
    logic [IDX_W-1:0]              mem_ra, mem_wa;
    logic                          mem_we;

    // shared compare/subtract unit
    logic [dtq_pkg::DELTA_W-1:0]   sub_a, sub_b;
    logic [dtq_pkg::DELTA_W:0]     sub_res;
    logic                          delta_ge_t;

    logic                          in_xfer;
    logic                          out_free;
    logic                          due;

    // logical position to physical address in the circular buffer
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(NUM_ENTRIES))
            sum = sum - SUM_W'(NUM_ENTRIES);
        return sum[IDX_W-1:0];
    endfunction

    assign in_ready = (state_reg == dtq_pkg::ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign due      = (rd_data_reg.delta == '0);

    assign out_valid    = out_valid_reg;
    assign result_valid = o_valid_reg;
    assign expired_id   = o_id_reg;
    assign expired_arg  = o_arg_reg;
    assign queue_full   = o_full_reg;
    assign last_result  = o_last_reg;

    // operand select: age a delta, fix a successor, or consume delay
    always_comb
    begin
        unique case (state_reg)
            dtq_pkg::ST_TK_EV:
            begin
                sub_a = rd_data_reg.delta;
                sub_b = {{(dtq_pkg::DELTA_W-1){1'b0}}, 1'b1};
            end
            dtq_pkg::ST_FX_WR:
            begin
                sub_a = rd_data_reg.delta;
                sub_b = t_reg;
            end
            default:
            begin
                sub_a = t_reg;
                sub_b = rd_data_reg.delta;
            end
        endcase
    end

    // borrow or zero means the stored delta is not below the remaining delay
    assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
    assign delta_ge_t = sub_res[dtq_pkg::DELTA_W]
                        || (sub_res[dtq_pkg::DELTA_W-1:0] == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    priority if (action == dtq_pkg::ACT_TICK)
                        state_next = (count_reg == '0) ? dtq_pkg::ST_EMIT
                                                       : dtq_pkg::ST_TK_RD;
                    else if (action == dtq_pkg::ACT_INSERT)
                    begin
                        priority if (count_reg == CNT_W'(NUM_ENTRIES))
                            state_next = dtq_pkg::ST_EMIT;
                        else if (count_reg == '0)
                            state_next = dtq_pkg::ST_IN_PUT;
                        else
                            state_next = dtq_pkg::ST_IN_RD;
                    end
                    else if (action == dtq_pkg::ACT_EXPIRE)
                        state_next = (frozen_reg || count_reg == '0) ? dtq_pkg::ST_EMIT
                                                                     : dtq_pkg::ST_EX_RD;
                    else
                        state_next = dtq_pkg::ST_EMIT;
                end
            end
            dtq_pkg::ST_TK_RD: state_next = dtq_pkg::ST_TK_EV;
            dtq_pkg::ST_TK_EV:
            begin
                if (!due || idx_reg + 1'b1 == count_reg)
                    state_next = dtq_pkg::ST_EMIT;
                else
                    state_next = dtq_pkg::ST_TK_RD;
            end
            dtq_pkg::ST_IN_RD: state_next = dtq_pkg::ST_IN_EV;
            dtq_pkg::ST_IN_EV:
            begin
                priority if (delta_ge_t)
                    state_next = dtq_pkg::ST_SH_RD;
                else if (idx_reg + 1'b1 == count_reg)
                    state_next = dtq_pkg::ST_IN_PUT;
                else
                    state_next = dtq_pkg::ST_IN_RD;
            end
            dtq_pkg::ST_SH_RD: state_next = dtq_pkg::ST_SH_WR;
            dtq_pkg::ST_SH_WR:
                state_next = (j_reg - 1'b1 == idx_reg) ? dtq_pkg::ST_IN_PUT
                                                       : dtq_pkg::ST_SH_RD;
            dtq_pkg::ST_IN_PUT:
                state_next = (idx_reg < count_reg) ? dtq_pkg::ST_FX_RD
                                                   : dtq_pkg::ST_EMIT;
            dtq_pkg::ST_FX_RD: state_next = dtq_pkg::ST_FX_WR;
            dtq_pkg::ST_FX_WR: state_next = dtq_pkg::ST_EMIT;
            dtq_pkg::ST_EX_RD: state_next = dtq_pkg::ST_EX_EV;
            dtq_pkg::ST_EX_EV:
            begin
                if (!pend_reg || out_free)
                begin
                    priority if (!due)
                        state_next = pend_reg ? dtq_pkg::ST_IDLE : dtq_pkg::ST_EMIT;
                    else if (count_reg > CNT_W'(1)
                             && n_reg + 1'b1 < N_W'(dtq_pkg::MAX_RESULTS))
                        state_next = dtq_pkg::ST_EX_RD;
                    else
                        state_next = dtq_pkg::ST_EX_OUT;
                end
            end
            dtq_pkg::ST_EX_OUT:
                if (out_free)
                    state_next = dtq_pkg::ST_IDLE;
            dtq_pkg::ST_EMIT:
                if (out_free)
                    state_next = dtq_pkg::ST_IDLE;
            default: state_next = dtq_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory port and output register controls
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        t_next         = t_reg;
        id_next        = id_reg;
        arg_next       = arg_reg;
        rv_next        = rv_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_valid_next   = o_valid_reg;
        o_id_next      = o_id_reg;
        o_arg_next     = o_arg_reg;
        o_full_next    = o_full_reg;
        o_last_next    = o_last_reg;
        mem_ra         = phys(head_reg, idx_reg);
        mem_wa         = phys(head_reg, idx_reg);
        mem_we         = 1'b0;
        mem_wd         = rd_data_reg;

        unique case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next  = '0;
                    n_next    = '0;
                    pend_next = 1'b0;
                    t_next    = delay_ticks;
                    id_next   = callback_id;
                    arg_next  = callback_arg;
                    full_next = 1'b0;
                    rv_next   = 1'b0;
                    priority if (action == dtq_pkg::ACT_TICK)
                        rv_next = 1'b1;
                    else if (action == dtq_pkg::ACT_INSERT)
                    begin
                        rv_next   = (count_reg != CNT_W'(NUM_ENTRIES));
                        full_next = (count_reg == CNT_W'(NUM_ENTRIES));
                    end
                    else
                        rv_next = 1'b0;
                end
            end
            dtq_pkg::ST_TK_RD:
            begin
                mem_ra = phys(head_reg, idx_reg);
            end
            // age the first nonzero delta
            dtq_pkg::ST_TK_EV:
            begin
                if (!due)
                begin
                    mem_we       = 1'b1;
                    mem_wa       = phys(head_reg, idx_reg);
                    mem_wd.delta = sub_res[dtq_pkg::DELTA_W-1:0];
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            dtq_pkg::ST_IN_RD:
            begin
                mem_ra = phys(head_reg, idx_reg);
            end
            // consume delay while the stored delta is smaller
            dtq_pkg::ST_IN_EV:
            begin
                if (!delta_ge_t)
                begin
                    t_next   = sub_res[dtq_pkg::DELTA_W-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                else
                    j_next = count_reg;
            end
            // move entries one place toward the tail
            dtq_pkg::ST_SH_RD:
            begin
                mem_ra = phys(head_reg, j_reg - 1'b1);
            end
            dtq_pkg::ST_SH_WR:
            begin
                mem_we = 1'b1;
                mem_wa = phys(head_reg, j_reg);
                j_next = j_reg - 1'b1;
            end
            dtq_pkg::ST_IN_PUT:
            begin
                mem_we        = 1'b1;
                mem_wa        = phys(head_reg, idx_reg);
                mem_wd.delta  = t_reg;
                mem_wd.cb_id  = id_reg;
                mem_wd.cb_arg = arg_reg;
                count_next    = count_reg + 1'b1;
            end
            // successor delta now relative to the new entry
            dtq_pkg::ST_FX_RD:
            begin
                mem_ra = phys(head_reg, idx_reg + 1'b1);
            end
            dtq_pkg::ST_FX_WR:
            begin
                mem_we       = 1'b1;
                mem_wa       = phys(head_reg, idx_reg + 1'b1);
                mem_wd.delta = sub_res[dtq_pkg::DELTA_W-1:0];
            end
            dtq_pkg::ST_EX_RD:
            begin
                mem_ra = head_reg;
            end
            // pop a due head, report the previous one once its successor is known
            dtq_pkg::ST_EX_EV:
            begin
                mem_ra = head_reg;
                if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        o_valid_next   = 1'b1;
                        o_id_next      = id_reg;
                        o_arg_next     = arg_reg;
                        o_full_next    = 1'b0;
                        o_last_next    = !due;
                    end
                    if (due)
                    begin
                        id_next    = rd_data_reg.cb_id;
                        arg_next   = rd_data_reg.cb_arg;
                        head_next  = phys(head_reg, CNT_W'(1));
                        count_next = count_reg - 1'b1;
                        n_next     = n_reg + 1'b1;
                        pend_next  = 1'b1;
                    end
                end
            end
            dtq_pkg::ST_EX_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_valid_next   = 1'b1;
                    o_id_next      = id_reg;
                    o_arg_next     = arg_reg;
                    o_full_next    = 1'b0;
                    o_last_next    = 1'b1;
                end
            end
            dtq_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_valid_next   = rv_reg;
                    o_id_next      = '0;
                    o_arg_next     = '0;
                    o_full_next    = full_reg;
                    o_last_next    = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtq_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            frozen_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                frozen_reg <= cfg_wr_data;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        j_reg       <= j_next;
        n_reg       <= n_next;
        pend_reg    <= pend_next;
        t_reg       <= t_next;
        id_reg      <= id_next;
        arg_reg     <= arg_next;
        rv_reg      <= rv_next;
        full_reg    <= full_next;
        o_valid_reg <= o_valid_next;
        o_id_reg    <= o_id_next;
        o_arg_reg   <= o_arg_next;
        o_full_reg  <= o_full_next;
        o_last_reg  <= o_last_next;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_ENTRIES))
        else $error("queue count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg)
             || count_reg == $past(count_reg) + 1'b1
             || count_reg + 1'b1 == $past(count_reg)))
        else $error("queue count moved by more than one");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == dtq_pkg::ST_TK_EV || state_reg == dtq_pkg::ST_SH_WR
                    || state_reg == dtq_pkg::ST_IN_PUT || state_reg == dtq_pkg::ST_FX_WR))
        else $error("memory write outside a writing step");

    a_not_last_is_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !o_last_reg) |-> (o_valid_reg && !o_full_reg))
        else $error("non-final result that is not a popped entry");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtq_pkg::ST_EX_OUT) |-> pend_reg)
        else $error("final expire result without a popped entry");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the delta timer queue. A shadow copy of the queue,
// kept as relative deltas, predicts the report of every transfer. Directed
// tests cover ticks, inserts, expires, the unused action, a full queue and
// frozen callouts. Random traffic then runs under bursty input and a
// stalling output.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QUEUE_DEPTH = dtq_pkg::NUM_ENTRIES_DEF;
    localparam logic [dtq_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4 * QUEUE_DEPTH + 16;
    localparam int DRAIN_LIMIT = 20000;

    // one report on the output channel
    typedef struct packed {
        logic                      valid;
        logic [dtq_pkg::ID_W-1:0]  id;
        logic [dtq_pkg::ARG_W-1:0] arg;
        logic                      full;
        logic                      last;
    } timer_report_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC
    } ready_mode_t;

    logic                         clk;
    logic                         rst_n        = 1'b0;
    logic                         cfg_wr_en    = 1'b0;
    logic                         cfg_wr_data  = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_ready;
    logic [dtq_pkg::ACTION_W-1:0] action       = dtq_pkg::ACT_TICK;
    logic [dtq_pkg::DELTA_W-1:0]  delay_ticks  = '0;
    logic [dtq_pkg::ID_W-1:0]     callback_id  = '0;
    logic [dtq_pkg::ARG_W-1:0]    callback_arg = '0;
    logic                         out_valid;
    logic                         out_ready    = 1'b0;
    logic                         result_valid;
    logic [dtq_pkg::ID_W-1:0]     expired_id;
    logic [dtq_pkg::ARG_W-1:0]    expired_arg;
    logic                         queue_full;
    logic                         last_result;

    // shadow copy of the timer queue
    logic [dtq_pkg::DELTA_W-1:0] copy_delta [QUEUE_DEPTH];
    logic [dtq_pkg::ID_W-1:0]    copy_id    [QUEUE_DEPTH];
    logic [dtq_pkg::ARG_W-1:0]   copy_arg   [QUEUE_DEPTH];
    int                          copy_count  = 0;
    logic                        copy_frozen = 1'b0;

    timer_report_t pending_reports [$];
    int            mismatch_count = 0;

    // sender burst control
    int gap_max    = 0;
    int burst_left = 0;

    // receiver stall pattern
    ready_mode_t ready_mode  = RDY_ALWAYS;
    int          mode_left   = 0;
    int          stall_len   = 0;
    logic [2:0]  stall_phase = '0;

    delta_timer_queue_top #(
        .NUM_ENTRIES (QUEUE_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .delay_ticks  (delay_ticks),
        .callback_id  (callback_id),
        .callback_arg (callback_arg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_valid (result_valid),
        .expired_id   (expired_id),
        .expired_arg  (expired_arg),
        .queue_full   (queue_full),
        .last_result  (last_result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic timer_report_t report(input logic v,
                                             input logic [dtq_pkg::ID_W-1:0] cid,
                                             input logic [dtq_pkg::ARG_W-1:0] carg,
                                             input logic full, input logic last);
        timer_report_t r;
        r.valid = v;
        r.id    = cid;
        r.arg   = carg;
        r.full  = full;
        r.last  = last;
        return r;
    endfunction

    // apply one accepted item to the shadow queue and queue up its reports
    function automatic void advance_timer_copy(input logic [dtq_pkg::ACTION_W-1:0] act,
                                               input logic [dtq_pkg::DELTA_W-1:0] dly,
                                               input logic [dtq_pkg::ID_W-1:0] cid,
                                               input logic [dtq_pkg::ARG_W-1:0] carg);
        int                          pos;
        int                          j;
        int                          popped;
        bit                          done;
        logic [dtq_pkg::DELTA_W-1:0] left;
        pos    = 0;
        popped = 0;
        done   = 1'b0;
        left   = dly;
        case (act)
            dtq_pkg::ACT_TICK:
            begin
                // age the first nonzero delta
                for (j = 0; j < copy_count; j++)
                begin
                    if (!done && copy_delta[j] != '0)
                    begin
                        copy_delta[j] = copy_delta[j] - 1'b1;
                        done = 1'b1;
                    end
                end
                pending_reports.push_back(report(1'b1, '0, '0, 1'b0, 1'b1));
            end
            dtq_pkg::ACT_INSERT:
            begin
                if (copy_count >= QUEUE_DEPTH)
                begin
                    pending_reports.push_back(report(1'b0, '0, '0, 1'b1, 1'b1));
                end
                else
                begin
                    // walk past entries that are due strictly earlier
                    while (pos < copy_count && copy_delta[pos] < left)
                    begin
                        left = left - copy_delta[pos];
                        pos++;
                    end
                    for (j = copy_count; j > pos; j--)
                    begin
                        copy_delta[j] = copy_delta[j-1];
                        copy_id[j]    = copy_id[j-1];
                        copy_arg[j]   = copy_arg[j-1];
                    end
                    copy_delta[pos] = left;
                    copy_id[pos]    = cid;
                    copy_arg[pos]   = carg;
                    copy_count++;
                    if (pos + 1 < copy_count)
                        copy_delta[pos+1] = copy_delta[pos+1] - left;
                    pending_reports.push_back(report(1'b1, '0, '0, 1'b0, 1'b1));
                end
            end
            dtq_pkg::ACT_EXPIRE:
            begin
                if (!copy_frozen)
                begin
                    while (popped < copy_count && popped < dtq_pkg::MAX_RESULTS &&
                           copy_delta[popped] == '0)
                        popped++;
                end
                if (popped == 0)
                begin
                    pending_reports.push_back(report(1'b0, '0, '0, 1'b0, 1'b1));
                end
                else
                begin
                    for (j = 0; j < popped; j++)
                        pending_reports.push_back(report(1'b1, copy_id[j], copy_arg[j],
                                                         1'b0, j + 1 == popped));
                    for (j = popped; j < copy_count; j++)
                    begin
                        copy_delta[j-popped] = copy_delta[j];
                        copy_id[j-popped]    = copy_id[j];
                        copy_arg[j-popped]   = copy_arg[j];
                    end
                    copy_count = copy_count - popped;
                end
            end
            default:
            begin
                pending_reports.push_back(report(1'b0, '0, '0, 1'b0, 1'b1));
            end
        endcase
    endfunction

    function automatic void check_field(input string name,
                                        input logic [dtq_pkg::ARG_W-1:0] want,
                                        input logic [dtq_pkg::ARG_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // compare each output transfer with the oldest predicted report
    always @(posedge clk)
    begin
        timer_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("output transfer with no report pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("result_valid", dtq_pkg::ARG_W'(want.valid),
                            dtq_pkg::ARG_W'(result_valid));
                check_field("expired_id", dtq_pkg::ARG_W'(want.id),
                            dtq_pkg::ARG_W'(expired_id));
                check_field("expired_arg", want.arg, expired_arg);
                check_field("queue_full", dtq_pkg::ARG_W'(want.full),
                            dtq_pkg::ARG_W'(queue_full));
                check_field("last_result", dtq_pkg::ARG_W'(want.last),
                            dtq_pkg::ARG_W'(last_result));
            end
        end
    end

    // receiver ready pattern, switching between modes
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            mode_left  = $urandom_range(20, 120);
            stall_len  = $urandom_range(1, 7);
        end
        else
        begin
            mode_left--;
        end
        stall_phase = stall_phase + 1'b1;
        case (ready_mode)
            RDY_ALWAYS: out_ready <= 1'b1;
            RDY_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
            default:    out_ready <= (int'(stall_phase) >= stall_len);
        endcase
    end

    // present one item and wait for its transfer
    task automatic send_item(input logic [dtq_pkg::ACTION_W-1:0] act,
                             input logic [dtq_pkg::DELTA_W-1:0] dly,
                             input logic [dtq_pkg::ID_W-1:0] cid,
                             input logic [dtq_pkg::ARG_W-1:0] carg);
        int gap;
        gap = 0;
        if (gap_max > 0)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, gap_max);
                burst_left = $urandom_range(1, 12);
            end
            else
            begin
                burst_left--;
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        delay_ticks  <= dly;
        callback_id  <= cid;
        callback_arg <= carg;
        do
            @(posedge clk);
        while (!in_ready);
        advance_timer_copy(act, dly, cid, carg);
    endtask

    // stop sending, wait for all reports, then let the sequencer finish
    task automatic settle_idle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_reports.size() != 0)
        begin
            $error("%0d reports never arrived", pending_reports.size());
            mismatch_count++;
            pending_reports.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frozen(input logic value);
        settle_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        copy_frozen = value;
    endtask

    function automatic logic [dtq_pkg::DELTA_W-1:0] pick_delay();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return dtq_pkg::DELTA_W'($urandom_range(0, 6));
        else if (sel < 94)
            return dtq_pkg::DELTA_W'($urandom_range(0, 300));
        else
            return dtq_pkg::DELTA_W'($urandom_range(0, 24'hFFFFFF));
    endfunction

    // ticks, inserts, expires and the unused action with hand-picked values, no idling
    task automatic test_directed_ops();
        gap_max = 0;
        send_item(dtq_pkg::ACT_TICK, '0, '0, '0);
        send_item(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
        send_item(ACT_UNUSED, '1, '1, '1);
        send_item(dtq_pkg::ACT_INSERT, 24'd5, 16'h0000, 32'h0000_0000);
        // equal delay goes ahead of the existing entry
        send_item(dtq_pkg::ACT_INSERT, 24'd5, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(dtq_pkg::ACT_INSERT, 24'd7, 16'h00A5, 32'h5A5A_A5A5);
        send_item(dtq_pkg::ACT_INSERT, 24'd0, 16'h1234, 32'h8765_4321);
        send_item(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
        repeat (5) send_item(dtq_pkg::ACT_TICK, '0, '0, '0);
        // zero delay lands in front of entries already due
        send_item(dtq_pkg::ACT_INSERT, 24'd0, 16'h5A5A, 32'hC001_D00D);
        send_item(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
        repeat (2) send_item(dtq_pkg::ACT_TICK, '0, '0, '0);
        send_item(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
        send_item(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
    endtask

    // frozen callouts still age but never pop
    task automatic test_frozen_callouts();
        write_frozen(1'b1);
        gap_max = 2;
        send_item(dtq_pkg::ACT_INSERT, 24'd0, 16'h0F0F, 32'h1111_2222);
        send_item(dtq_pkg::ACT_INSERT, 24'd1, 16'hF0F0, 32'h3333_4444);
        send_item(dtq_pkg::ACT_TICK, '0, '0, '0);
        // tick on an all-zero queue changes nothing
        send_item(dtq_pkg::ACT_TICK, '0, '0, '0);
        send_item(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
        write_frozen(1'b0);
        send_item(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
    endtask

    // fill every entry, get refused, then pop the whole queue at once
    task automatic test_fill_and_flush();
        gap_max = 3;
        while (copy_count < QUEUE_DEPTH)
            send_item(dtq_pkg::ACT_INSERT, dtq_pkg::DELTA_W'($urandom_range(0, 3)),
                      dtq_pkg::ID_W'($urandom), $urandom);
        send_item(dtq_pkg::ACT_INSERT, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(dtq_pkg::ACT_INSERT, 24'd0, 16'h0000, 32'h0000_0000);
        repeat (3) send_item(dtq_pkg::ACT_TICK, '0, '0, '0);
        send_item(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
        send_item(dtq_pkg::ACT_EXPIRE, '0, '0, '0);
    endtask

    // weighted random traffic, mostly inserts, ticks and expires
    task automatic test_random_traffic(input int item_total, input int gap_limit);
        int n;
        int sel;
        logic [dtq_pkg::ACTION_W-1:0] act;
        gap_max = gap_limit;
        for (n = 0; n < item_total; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                act = dtq_pkg::ACT_INSERT;
            else if (sel < 72)
                act = dtq_pkg::ACT_TICK;
            else if (sel < 95)
                act = dtq_pkg::ACT_EXPIRE;
            else
                act = ACT_UNUSED;
            send_item(act, pick_delay(), dtq_pkg::ID_W'($urandom), $urandom);
        end
    endtask

    // test sequence
    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_frozen_callouts();
        test_fill_and_flush();
        test_random_traffic(80, 6);
        write_frozen(1'b1);
        test_random_traffic(30, 2);
        write_frozen(1'b0);
        test_random_traffic(45, 0);
        settle_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
